// ===== rtl/core/bra_pkg.sv =====
// Package for the bitmap run allocator: field widths, codes, default sizes
// and the small bit helpers used by the top level; the interfaces take only the widths.
// Depends on nothing.
package bra_pkg;

	localparam int DEF_MAP_BYTES = 512;
	localparam int DEF_MAX_RUN   = 4096;

	localparam int ADDR_W   = 9;
	localparam int DATA_W   = 8;
	localparam int LEN_W    = 13;
	localparam int UNIT_W   = 17;
	localparam int STATUS_W = 2;
	localparam int USED_W   = 10;
	localparam int BIAS_W   = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [USED_W-1:0] RESET_MAP_BYTES_USED = USED_W'(512);
	localparam logic [BIAS_W-1:0] RESET_NUMBER_BIAS    = '0;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_BYTES_USED = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BIAS    = CFG_IDX_W'(1);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_ALLOC = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_HIT    = 2'd2;

	localparam logic [DATA_W-1:0] BYTE_FULL = 8'hFF;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FIT,
		ST_CHECK,
		ST_MARK,
		ST_DONE
	} state_t;

	// Index of the lowest clear bit; only meaningful for a byte that is not full.
	function automatic logic [2:0] first_zero(input logic [DATA_W-1:0] b);
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (!b[i]) pos = 3'(i);
		end
		return pos;
	endfunction

	// Bits of one byte that belong to a run starting at lo_bit in the first
	// byte and ending at hi_bit in the last byte.
	function automatic logic [DATA_W-1:0] run_mask(input logic is_first, input logic is_last,
			input logic [2:0] lo_bit, input logic [2:0] hi_bit);
		logic [DATA_W-1:0] lo_m;
		logic [DATA_W-1:0] hi_m;
		lo_m = is_first ? (BYTE_FULL << lo_bit) : BYTE_FULL;
		hi_m = is_last ? (BYTE_FULL >> (3'd7 - hi_bit)) : BYTE_FULL;
		return lo_m & hi_m;
	endfunction

endpackage

// ===== rtl/core/bra_req_if.sv =====
// Request channel of the bitmap run allocator: valid/ready plus item fields.
// Depends on bra_pkg for the field widths.
interface bra_req_if;
	import bra_pkg::*;

	logic              valid;
	logic              ready;
	logic              func;
	logic [ADDR_W-1:0] byte_address;
	logic [DATA_W-1:0] byte_data;
	logic [LEN_W-1:0]  run_length;

	modport source (output valid, output func, output byte_address, output byte_data,
		output run_length, input ready);
	modport sink (input valid, input func, input byte_address, input byte_data,
		input run_length, output ready);
endinterface

// ===== rtl/core/bra_rsp_if.sv =====
// Response channel of the bitmap run allocator: valid/ready plus result fields.
// Depends on bra_pkg for the field widths.
interface bra_rsp_if;
	import bra_pkg::*;

	logic                valid;
	logic                ready;
	logic [UNIT_W-1:0]   unit_number;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output unit_number, output status, input ready);
	modport sink (input valid, input unit_number, input status, output ready);
endinterface

// ===== rtl/core/bra_cfg_if.sv =====
// Configuration write channel of the bitmap run allocator.
// Depends on bra_pkg for the index and data widths.
interface bra_cfg_if;
	import bra_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bitmap_run_allocator_top.sv =====
// Bitmap run allocator, top level: control sequencer, configuration and result register.
// Depends on bra_pkg, the three channel interfaces and bra_byte_store.
//
// First-fit allocator over a bitmap of MAP_BYTES bytes held in one synchronous RAM. After
// reset the block sweeps the RAM to zero, one byte a cycle, and takes no request until the
// sweep ends; configuration writes are taken at any time. A byte write goes to the RAM as
// the request is taken. An allocation is sequenced over the single RAM read port: the search
// streams one byte a cycle until the first byte that is not full, the run check streams the
// bytes the run covers, and the marking pass writes them back one a cycle. One request is in
// work at a time; the next one is taken while the last result still waits in the output
// register.
module bitmap_run_allocator_top #(
	parameter int MAP_BYTES = bra_pkg::DEF_MAP_BYTES,
	parameter int MAX_RUN   = bra_pkg::DEF_MAX_RUN
) (
	input  logic   clk,
	input  logic   arst_n,
	bra_req_if.sink   req,
	bra_rsp_if.source rsp,
	bra_cfg_if.sink   cfg
);
	import bra_pkg::*;

	localparam int AW = $clog2(MAP_BYTES);
	localparam int BW = AW + 3;
	localparam int CW = (BW + 1 > LEN_W + 1) ? BW + 1 : LEN_W + 1;

	state_t state_q, state_d;

	logic [USED_W-1:0] map_bytes_used_q;
	logic [BIAS_W-1:0] number_bias_q;

	logic [AW:0]        iss_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;
	logic [BW-1:0]      start_q;
	logic [BW-1:0]      end_q;
	logic [LEN_W-1:0]   len_q;
	logic [DATA_W-1:0]  old_first_q;
	logic [DATA_W-1:0]  old_last_q;
	logic [UNIT_W-1:0]  res_unit_q;
	logic [STATUS_W-1:0] res_status_q;
	logic               out_vld_q;
	logic [UNIT_W-1:0]  out_unit_q;
	logic [STATUS_W-1:0] out_status_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	logic [AW:0]       used;
	logic [CW-1:0]     total_bits;
	logic [CW-1:0]     room;
	logic [CW-1:0]     run_end;
	logic [AW:0]       sb;
	logic [AW:0]       eb;
	logic              req_fire;
	logic              too_long;
	logic              done_load;
	logic              scan_hit;
	logic              scan_miss;
	logic [DATA_W-1:0] chk_mask;
	logic              chk_hit;
	logic              chk_last;
	logic [DATA_W-1:0] mark_mask;
	logic [DATA_W-1:0] mark_old;
	logic              issue;
	logic              addr_ok;

	bra_byte_store #(
		.DEPTH(MAP_BYTES),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign used = (32'(map_bytes_used_q) > MAP_BYTES) ? (AW+1)'(MAP_BYTES)
		: (AW+1)'(map_bytes_used_q);
	assign total_bits = CW'({used, 3'b000});
	assign room       = total_bits - CW'(start_q);
	assign run_end    = CW'(start_q) + CW'(len_q) - CW'(1);
	assign sb         = (AW+1)'(start_q[BW-1:3]);
	assign eb         = (AW+1)'(end_q[BW-1:3]);

	assign req_fire  = req.valid && req.ready;
	assign too_long  = 32'(req.run_length) > MAX_RUN;
	assign addr_ok   = 32'(req.byte_address) < MAP_BYTES;
	assign done_load = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);

	assign scan_hit  = vld_s1 && (mem_rdata != BYTE_FULL);
	assign scan_miss = vld_s1 && (mem_rdata == BYTE_FULL) && ((AW+1)'(idx_s1) == used - 1'b1);

	assign chk_mask = run_mask((AW+1)'(idx_s1) == sb, (AW+1)'(idx_s1) == eb,
		start_q[2:0], end_q[2:0]);
	assign chk_hit  = vld_s1 && ((mem_rdata & chk_mask) != '0);
	assign chk_last = vld_s1 && ((AW+1)'(idx_s1) == eb);

	assign mark_mask = run_mask(iss_q == sb, iss_q == eb, start_q[2:0], end_q[2:0]);
	assign mark_old  = (iss_q == sb) ? old_first_q : ((iss_q == eb) ? old_last_q : '0);

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid       = out_vld_q;
	assign rsp.unit_number = out_unit_q;
	assign rsp.status      = out_status_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = iss_q[AW-1:0];
		mem_wdata = '0;
		issue     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (iss_q == (AW+1)'(MAP_BYTES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_fire) begin
					if (req.func == FUNC_WRITE) begin
						mem_we    = addr_ok;
						mem_waddr = AW'(req.byte_address);
						mem_wdata = req.byte_data;
						state_d   = ST_DONE;
					end else if (too_long || used == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					state_d = ST_FIT;
				end else if (scan_miss) begin
					state_d = ST_DONE;
				end else begin
					issue = (iss_q < used);
				end
			end
			ST_FIT: begin
				if (CW'(len_q) > room) state_d = ST_DONE;
				else state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (chk_hit) begin
					state_d = ST_DONE;
				end else if (chk_last) begin
					state_d = ST_MARK;
				end else begin
					issue = (iss_q <= eb);
				end
			end
			ST_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = mark_old | mark_mask;
				if (iss_q == eb) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (done_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign mem_re    = issue;
	assign mem_raddr = iss_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer counters, pipeline tag and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q     <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) iss_q <= iss_q + 1'b1;
			unique case (state_q)
				ST_CLEAR: iss_q <= (state_d == ST_IDLE) ? '0 : iss_q + 1'b1;
				ST_IDLE:  iss_q <= '0;
				ST_FIT:   iss_q <= sb;
				ST_CHECK: if (chk_last && !chk_hit) iss_q <= sb;
				ST_MARK:  iss_q <= iss_q + 1'b1;
				default: ;
			endcase
			if (done_load) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) idx_s1 <= iss_q[AW-1:0];
		if (done_load) begin
			out_unit_q   <= res_unit_q;
			out_status_q <= res_status_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				len_q        <= (req.run_length == '0) ? LEN_W'(1) : req.run_length;
				res_unit_q   <= '0;
				res_status_q <= (req.func == FUNC_ALLOC && (too_long || used == '0))
					? STATUS_NO_FIT : STATUS_OK;
			end
			ST_SCAN: begin
				if (scan_hit) start_q <= {idx_s1, first_zero(mem_rdata)};
				if (scan_miss) res_status_q <= STATUS_NO_FIT;
			end
			ST_FIT: begin
				end_q <= run_end[BW-1:0];
				if (CW'(len_q) > room) res_status_q <= STATUS_NO_FIT;
			end
			ST_CHECK: begin
				if ((AW+1)'(idx_s1) == sb) old_first_q <= mem_rdata;
				if ((AW+1)'(idx_s1) == eb) old_last_q <= mem_rdata;
				if (chk_hit) res_status_q <= STATUS_HIT;
			end
			ST_MARK: begin
				if (iss_q == eb) begin
					res_unit_q   <= UNIT_W'(start_q) + UNIT_W'(number_bias_q);
					res_status_q <= STATUS_OK;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_bytes_used_q <= RESET_MAP_BYTES_USED;
			number_bias_q    <= RESET_NUMBER_BIAS;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MAP_BYTES_USED: map_bytes_used_q <= cfg.data[USED_W-1:0];
				REG_NUMBER_BIAS:    number_bias_q    <= cfg.data[BIAS_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/bra_byte_store.sv =====
// Bitmap byte store: one write port and one read port with registered data.
// Depends on nothing; sized by the parameters from the top level.
module bra_byte_store #(
	parameter int DEPTH = 512,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule
